// ----- hw/rtl/eps_pkg.sv -----
// Shared constants for the ellipse perimeter series pipeline: field widths,
// fixed-point formats, series coefficients and pipeline stage numbering.
// No dependencies.
package eps_pkg;

    // Input and result field widths.
    localparam int AXIS_BITS            = 16;
    localparam int RESULT_FRACTION_BITS = 8;
    localparam int PERIM_W              = 27;
    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = ((2 * AXIS_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PERIM_W + 7) / 8) * 8;

    // Sum of the axes and the ratio d/s in Q1.31.
    localparam int S_W          = AXIS_BITS + 1;
    localparam int R_W          = 32;
    localparam int R_FRAC       = R_W - 1;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES   = R_W / DIV_PER_STAGE;

    // h = r^2 in Q0.18.
    localparam int H_W    = 18;
    localparam int SQ_W   = 2 * R_W;
    localparam int SQ_SH  = 2 * R_FRAC - H_W;
    localparam logic [H_W-1:0] H_MAX = '1;
    localparam int PROD_W = 2 * H_W;

    // Series coefficients in Q0.24 and the accumulator in Q.42.
    localparam int N_TERMS   = 6;
    localparam int COEF_W    = 23;
    localparam int COEF_FRAC = 24;
    localparam int ACC_FRAC  = COEF_FRAC + H_W;
    localparam int ACC_W     = ACC_FRAC + 1;
    localparam logic [COEF_W-1:0] SERIES_COEF [0:N_TERMS-1] = '{
        23'd4194304, 23'd262144, 23'd65536, 23'd25600, 23'd12544, 23'd7056
    };
    localparam int SUM_W = 25;

    // Scaling by pi in Q.20.
    localparam int PI_W = 22;
    localparam logic [PI_W-1:0] PI_Q20 = 22'd3294199;
    localparam int T_W    = S_W + SUM_W;
    localparam int TI_W   = T_W - COEF_FRAC;
    localparam int MHI_W  = TI_W + PI_W;
    localparam int MLO_W  = COEF_FRAC + PI_W;
    localparam int Z_W    = MHI_W + 1;
    localparam int RES_SH = 20 - RESULT_FRACTION_BITS;
    localparam logic [Z_W:0] RES_RND = (RES_SH > 0) ? ((Z_W + 1)'(1) << (RES_SH - 1)) : '0;

    // Pipeline stage numbering.
    localparam int ST_IN   = 0;
    localparam int ST_SQ   = DIV_STAGES + 1;
    localparam int ST_H    = ST_SQ + 1;
    localparam int ST_SER0 = ST_H + 1;
    localparam int ST_SERN = ST_SER0 + N_TERMS - 1;
    localparam int ST_SUM  = ST_SERN + 1;
    localparam int ST_T    = ST_SUM + 1;
    localparam int ST_PI   = ST_T + 1;
    localparam int ST_Z    = ST_PI + 1;
    localparam int ST_OUT  = ST_Z + 1;
    localparam int N_ST    = ST_OUT + 1;

endpackage

// ----- hw/rtl/ellipse_perimeter_series.sv -----
// Ellipse perimeter by the seven-term Gauss-Kummer series, fully pipelined.
// Depends on eps_pkg.
//
//  channel  | direction | signals                  | contents (lowest bit first)
//  s_       | in        | s_tvalid s_tready s_tdata | semi_axis_a[15:0], semi_axis_b[31:16]
//  m_       | out       | m_tvalid m_tready m_tdata | perimeter[26:0], zero fill
//           |           | m_tuser                  | degenerate[0]
//
// One word is accepted per cycle while the pipe has room; each word passes through
// the 8-stage radix-16 restoring divider and then the multiplier chain of the series.
// Every stage holds a valid bit; a stage loads when it is empty or the next one loads,
// so bubbles close up while the output is stalled and nothing is lost or repeated.
// aresetn is synchronous and clears the valid bits only.
module ellipse_perimeter_series
    import eps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // semi_axis_a, semi_axis_b
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // perimeter, zero fill
    output logic [0:0]           m_tuser    // degenerate
);

    logic [N_ST-1:0] vld_reg;
    logic [N_ST-1:0] rdy;

    logic [S_W-1:0]    s_reg   [0:ST_SUM];
    logic              deg_reg [0:ST_Z];
    logic [S_W-1:0]    rem_reg [0:DIV_STAGES];
    logic [R_W-1:0]    q_reg   [0:DIV_STAGES];
    logic [R_W-1:0]    nlo_reg [0:DIV_STAGES];
    logic [SQ_W-1:0]   sq_reg;
    logic [H_W-1:0]    h_reg   [ST_H:ST_SERN-2];
    logic [ACC_W-1:0]  acc_reg [0:N_TERMS-1];
    logic [PROD_W-1:0] prod_reg [0:N_TERMS-2];
    logic [SUM_W-1:0]  sum_reg;
    logic [T_W-1:0]    t_reg;
    logic [MHI_W-1:0]  mhi_reg;
    logic [MLO_W-1:0]  mlo_reg;
    logic [Z_W-1:0]    z_reg;
    logic [PERIM_W-1:0] perim_reg;
    logic              degen_reg;

    logic [AXIS_BITS-1:0] axis_a, axis_b;
    logic [S_W-1:0]       sum_in, diff_in;

    // Ready chain: a stage may load when it is empty or its successor loads.
    always_comb begin
        rdy[N_ST-1] = !vld_reg[N_ST-1] || m_tready;
        for (int i = N_ST - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[ST_IN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[ST_IN]) begin
                vld_reg[ST_IN] <= s_tvalid;
            end
            for (int i = 1; i < N_ST; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Axis sum and the degenerate flag travel down the pipe beside the arithmetic.
    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) begin
            s_reg[ST_IN]   <= sum_in;
            deg_reg[ST_IN] <= (sum_in == '0);
        end
        for (int i = 1; i <= ST_SUM; i++) begin
            if (rdy[i]) begin
                s_reg[i] <= s_reg[i-1];
            end
        end
        for (int i = 1; i <= ST_Z; i++) begin
            if (rdy[i]) begin
                deg_reg[i] <= deg_reg[i-1];
            end
        end
    end

    assign axis_a  = s_tdata[AXIS_BITS-1:0];
    assign axis_b  = s_tdata[2*AXIS_BITS-1:AXIS_BITS];
    assign sum_in  = S_W'(axis_a) + S_W'(axis_b);
    assign diff_in = (axis_a >= axis_b) ? S_W'(axis_a - axis_b) : S_W'(axis_b - axis_a);

    // The dividend is d * 2^31 + s/2; its bits above bit 31 seed the remainder.
    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) begin
            rem_reg[0]     <= diff_in >> 1;
            q_reg[0]       <= '0;
            nlo_reg[0]     <= {diff_in[0], (R_W - 1)'(sum_in >> 1)};
        end
    end

    // Restoring divider, four quotient bits per stage.
    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        logic [S_W-1:0] rem_next;
        logic [R_W-1:0] q_next, nlo_next;

        always_comb begin
            logic [S_W:0] trial;
            rem_next = rem_reg[g-1];
            q_next   = q_reg[g-1];
            nlo_next = nlo_reg[g-1];
            for (int k = 0; k < DIV_PER_STAGE; k++) begin
                trial    = {rem_next, nlo_next[R_W-1]};
                nlo_next = nlo_next << 1;
                if (trial >= {1'b0, s_reg[g-1]}) begin
                    rem_next = S_W'(trial - {1'b0, s_reg[g-1]});
                    q_next   = {q_next[R_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[S_W-1:0];
                    q_next   = {q_next[R_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g]) begin
                rem_reg[g] <= rem_next;
                q_reg[g]   <= q_next;
                nlo_reg[g] <= nlo_next;
            end
        end
    end

    // r squared, then rounded and saturated to Q0.18.
    logic [SQ_W:0] h_sum;
    logic [SQ_W:0] h_wide;

    assign h_sum  = (SQ_W + 1)'(sq_reg) + ((SQ_W + 1)'(1) << (SQ_SH - 1));
    assign h_wide = h_sum >> SQ_SH;

    always_ff @(posedge aclk) begin
        if (rdy[ST_SQ]) begin
            sq_reg <= SQ_W'(q_reg[DIV_STAGES]) * SQ_W'(q_reg[DIV_STAGES]);
        end
        if (rdy[ST_H]) begin
            h_reg[ST_H] <= (h_wide > (SQ_W + 1)'(H_MAX)) ? H_MAX : h_wide[H_W-1:0];
        end
        for (int i = ST_H + 1; i < ST_SERN - 1; i++) begin
            if (rdy[i]) begin
                h_reg[i] <= h_reg[i-1];
            end
        end
        if (rdy[ST_SER0]) begin
            acc_reg[0]  <= (ACC_W'(1) << ACC_FRAC)
                         + ACC_W'(SERIES_COEF[0] * (COEF_W + H_W)'(h_reg[ST_H]));
            prod_reg[0] <= PROD_W'(h_reg[ST_H]) * PROD_W'(h_reg[ST_H]);
        end
    end

    // One series term per stage: round the previous power, add its term,
    // and, except at the last term, start the next power.
    for (genvar j = 1; j < N_TERMS; j++) begin : g_series
        logic [PROD_W:0] p_sum;
        logic [H_W-1:0]  p_cur;

        assign p_sum = (PROD_W + 1)'(prod_reg[j-1]) + ((PROD_W + 1)'(1) << (H_W - 1));
        assign p_cur = p_sum[H_W +: H_W];

        always_ff @(posedge aclk) begin
            if (rdy[ST_SER0 + j]) begin
                acc_reg[j] <= acc_reg[j-1]
                            + ACC_W'(SERIES_COEF[j] * (COEF_W + H_W)'(p_cur));
            end
        end

        if (j < N_TERMS - 1) begin : g_next_power
            always_ff @(posedge aclk) begin
                if (rdy[ST_SER0 + j]) begin
                    prod_reg[j] <= PROD_W'(p_cur) * PROD_W'(h_reg[ST_SER0 + j - 1]);
                end
            end
        end
    end

    // Series sum to Q.24, scale by s, then by pi with the product split into integer and fraction parts.
    logic [ACC_W:0]    acc_rnd;
    logic [MLO_W-1:0]  mlo_shift;
    logic [Z_W:0]      z_rnd;
    logic [Z_W:0]      res_wide;

    assign acc_rnd   = (ACC_W + 1)'(acc_reg[N_TERMS-1]) + ((ACC_W + 1)'(1) << (H_W - 1));
    assign mlo_shift = mlo_reg >> COEF_FRAC;
    assign z_rnd     = (Z_W + 1)'(z_reg) + RES_RND;
    assign res_wide  = z_rnd >> RES_SH;

    always_ff @(posedge aclk) begin
        if (rdy[ST_SUM]) begin
            sum_reg <= SUM_W'(acc_rnd >> H_W);
        end
        if (rdy[ST_T]) begin
            t_reg <= T_W'(s_reg[ST_SUM]) * T_W'(sum_reg);
        end
        if (rdy[ST_PI]) begin
            mhi_reg <= MHI_W'(t_reg[T_W-1:COEF_FRAC]) * MHI_W'(PI_Q20);
            mlo_reg <= MLO_W'(t_reg[COEF_FRAC-1:0]) * MLO_W'(PI_Q20);
        end
        if (rdy[ST_Z]) begin
            z_reg <= Z_W'(mhi_reg) + Z_W'(mlo_shift);
        end
        if (rdy[ST_OUT]) begin
            degen_reg <= deg_reg[ST_Z];
            if (deg_reg[ST_Z]) begin
                perim_reg <= '0;
            end else if (res_wide > (Z_W + 1)'(PERIM_MAX)) begin
                perim_reg <= PERIM_MAX;
            end else begin
                perim_reg <= res_wide[PERIM_W-1:0];
            end
        end
    end

    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = M_TDATA_W'(perim_reg);
    assign m_tuser  = degen_reg;

    // A degenerate word always carries a zero perimeter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[PERIM_W-1:0] == '0)
        else $error("degenerate word with non-zero perimeter");

    // The input can only be held off when the whole pipe is full behind a stalled output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && (&vld_reg))
        else $error("input stalled with room in the pipeline");

    // The divider leaves a remainder below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_STAGES] && !deg_reg[DIV_STAGES]
            |-> rem_reg[DIV_STAGES] < s_reg[DIV_STAGES])
        else $error("divider remainder out of range");

    // The ratio d/s never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_STAGES] && !deg_reg[DIV_STAGES]
            |-> q_reg[DIV_STAGES] <= (R_W'(1) << R_FRAC))
        else $error("ratio above one");

    // A stalled output word keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

endmodule
